// ===== hdl/sitoa_pkg.sv =====
// shared types, constants and helpers for the integer to ascii radix unit
package sitoa_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned DIG_W    = 4;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DEPTH    = 64;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W    = ADDR_W + 1;

  // decimal long division works on 16-bit chunks, top chunk first
  localparam int unsigned CHUNK_W  = 16;
  localparam int unsigned N_CHUNKS = DATA_W / CHUNK_W;
  localparam int unsigned CIDX_W   = $clog2(N_CHUNKS);
  localparam int unsigned DIVX_W   = CHUNK_W + DIG_W;
  localparam int unsigned RECIP_W  = 20;
  localparam int unsigned PROD_W   = DIVX_W + RECIP_W;

  // x / 10 == (x * RECIP_10) >> RECIP_SH for every x below 2^22
  localparam int unsigned RECIP_SH = 23;
  localparam logic [RECIP_W-1:0] RECIP_10 = RECIP_W'(838861);
  localparam logic [DIVX_W-1:0]  TEN      = DIVX_W'(10);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h61;
  localparam logic [CHAR_W-1:0] CH_MASK  = 8'hFF;
  localparam logic [DIG_W-1:0]  DIG_NINE = 4'd9;
  localparam logic [CHAR_W-1:0] DIG_TEN  = 8'd10;

  typedef enum logic [FUNC_W-1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] v;
    v = CHAR_W'(d);
    if (d > DIG_NINE) begin
      ascii_of = (v - DIG_TEN + CH_ALPHA) & CH_MASK;
    end else begin
      ascii_of = (v + CH_ZERO) & CH_MASK;
    end
  endfunction

endpackage

// ===== hdl/sitoa_if.sv =====
// valid/ready channel interfaces for the input and result beats
interface sitoa_in_if;
  import sitoa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic [FUNC_W-1:0]        func;

  modport source (output valid, output value, output func, input ready);
  modport sink   (input valid, input value, input func, output ready);
endinterface

interface sitoa_out_if;
  import sitoa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              negative;
  logic              last;

  modport source (output valid, output character, output negative, output last,
                  input ready);
  modport sink   (input valid, input character, input negative, input last,
                  output ready);
endinterface

// ===== hdl/signed_integer_to_ascii_radix_unit.sv =====
// top level: signed integer to ascii digits in radix 2, 8, 10 or 16
//
//  channel | dir | payload                        | beats per number
//  in_i    | in  | value[63:0] signed, func[1:0]  | 1
//  out_o   | out | character[7:0], negative, last | 1 to 64
//
// digits are found least significant first and kept in a 64x4 ram, then
// read back most significant first, one beat per cycle while out_o is ready
// radix 2, 8, 16: each digit is one shift of the magnitude; radix 10: each
// digit is one pass over the four 16-bit chunks, one chunk through the
// reciprocal multiplier each cycle; no clearing pass after reset
// a stalled out_o holds the read pipeline; a new beat on in_i is taken once
// all digits of the previous number have been read from the ram
module signed_integer_to_ascii_radix_unit #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sitoa_in_if.sink          in_i,
  sitoa_out_if.source       out_o
);
  import sitoa_pkg::*;

  localparam logic [DATA_W-1:0] VMASK = {DATA_W{1'b1}} >> (DATA_W - VALUE_BITS);

  state_e              state_q, state_d;
  radix_e              sel_q, sel_d;
  logic [DATA_W-1:0]   mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CIDX_W-1:0]   chunk_q, chunk_d;
  logic [DIG_W-1:0]    rem_q, rem_d;
  logic [ADDR_W-1:0]   ptr_q, ptr_d;

  logic                rv_q, rv_d;
  logic                rneg_q, rneg_d;
  logic                rlast_q, rlast_d;
  logic                ov_q, ov_d;
  logic [CHAR_W-1:0]   och_q;
  logic                oneg_q;
  logic                olast_q;

  logic                ram_we;
  logic [DIG_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [DIG_W-1:0]    ram_rdata;

  logic [DATA_W-1:0]   in_v;
  logic                in_sign;
  logic [CHUNK_W-1:0]  cur_chunk;
  logic [DIVX_W-1:0]   div_x;
  logic [PROD_W-1:0]   div_prod;
  logic [CHUNK_W-1:0]  div_q;
  logic [DIVX_W-1:0]   div_r;
  logic [DIG_W-1:0]    p2_dig;
  logic [DATA_W-1:0]   p2_mag;
  logic                load2;
  logic                issue;
  logic [ADDR_W-1:0]   first_ptr;

  sitoa_ram #(
    .WIDTH (DIG_W),
    .DEPTH (DEPTH)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // input magnitude
  assign in_v    = DATA_W'(in_i.value) & VMASK;
  assign in_sign = in_v[VALUE_BITS-1];

  // decimal chunk step
  assign cur_chunk = mag_q[(N_CHUNKS - 1 - chunk_q) * CHUNK_W +: CHUNK_W];
  assign div_x     = {rem_q, cur_chunk};
  assign div_prod  = PROD_W'(div_x) * PROD_W'(RECIP_10);
  assign div_q     = div_prod[RECIP_SH +: CHUNK_W];
  assign div_r     = div_x - DIVX_W'(div_q) * TEN;

  // power of two step
  always_comb begin
    unique case (sel_q)
      RADIX_BIN: begin
        p2_dig = DIG_W'(mag_q[0]);
        p2_mag = mag_q >> 1;
      end
      RADIX_OCT: begin
        p2_dig = DIG_W'(mag_q[2:0]);
        p2_mag = mag_q >> 3;
      end
      RADIX_HEX: begin
        p2_dig = mag_q[DIG_W-1:0];
        p2_mag = mag_q >> 4;
      end
      default: begin
        p2_dig = '0;
        p2_mag = mag_q;
      end
    endcase
  end

  assign load2     = rv_q && (!ov_q || out_o.ready);
  assign first_ptr = ADDR_W'(cnt_q - 1'b1);
  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    sel_d     = sel_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    chunk_d   = chunk_q;
    rem_d     = rem_q;
    ptr_d     = ptr_q;
    ram_we    = 1'b0;
    ram_wdata = p2_dig;
    issue     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          sel_d   = radix_e'(in_i.func);
          neg_d   = in_sign;
          mag_d   = in_sign ? ((~in_v + 1'b1) & VMASK) : in_v;
          cnt_d   = '0;
          chunk_d = '0;
          rem_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sel_q == RADIX_DEC) begin
          mag_d[(N_CHUNKS - 1 - chunk_q) * CHUNK_W +: CHUNK_W] = div_q;
          rem_d     = div_r[DIG_W-1:0];
          chunk_d   = chunk_q + 1'b1;
          ram_wdata = div_r[DIG_W-1:0];
          if (chunk_q == CIDX_W'(N_CHUNKS - 1)) begin
            ram_we  = 1'b1;
            cnt_d   = cnt_q + 1'b1;
            rem_d   = '0;
            chunk_d = '0;
            if (mag_d == '0) begin
              ptr_d   = cnt_q[ADDR_W-1:0];
              state_d = ST_EMIT;
            end
          end
        end else begin
          ram_we = 1'b1;
          mag_d  = p2_mag;
          cnt_d  = cnt_q + 1'b1;
          if (p2_mag == '0) begin
            ptr_d   = cnt_q[ADDR_W-1:0];
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        issue = !rv_q || load2;
        if (issue) begin
          ptr_d = ptr_q - 1'b1;
          if (ptr_q == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ram_re = issue;

  always_comb begin
    rv_d    = rv_q;
    rneg_d  = rneg_q;
    rlast_d = rlast_q;
    if (issue) begin
      rv_d    = 1'b1;
      rneg_d  = neg_q && (ptr_q == first_ptr);
      rlast_d = (ptr_q == '0);
    end else if (load2) begin
      rv_d = 1'b0;
    end
    ov_d = ov_q;
    if (load2) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= RADIX_BIN;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
      chunk_q <= '0;
      rem_q   <= '0;
      ptr_q   <= '0;
      rv_q    <= 1'b0;
      rneg_q  <= 1'b0;
      rlast_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      cnt_q   <= cnt_d;
      chunk_q <= chunk_d;
      rem_q   <= rem_d;
      ptr_q   <= ptr_d;
      rv_q    <= rv_d;
      rneg_q  <= rneg_d;
      rlast_q <= rlast_d;
      ov_q    <= ov_d;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (load2) begin
      och_q   <= ascii_of(ram_rdata);
      oneg_q  <= rneg_q;
      olast_q <= rlast_q;
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.character = och_q;
  assign out_o.negative  = oneg_q;
  assign out_o.last      = olast_q;

endmodule

// ===== hdl/sitoa_ram.sv =====
// generic simple dual-port ram with registered read
module sitoa_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
